// ----- rtl/sfh_pkg.sv -----
package sfh_pkg;

  localparam int SYMBOL_BITS = 16;
  localparam int COUNT_BITS  = 20;
  localparam int DIST_BITS   = SYMBOL_BITS + 1;

  localparam int IN_WIDTH      = ((SYMBOL_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_WIDTH = SYMBOL_BITS + COUNT_BITS + DIST_BITS;
  localparam int OUT_WIDTH     = ((OUT_RAW_WIDTH + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0]  NUM_SYMS = {1'b1, {SYMBOL_BITS{1'b0}}};

  localparam logic MODE_COUNT = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef struct packed {
    logic clear_wr;   // write zero at the clearing address
    logic cnt_rd;     // read the count of the incoming symbol
    logic cnt_upd;    // write back the incremented count
    logic scan_rd;    // read the count at the scan position
    logic scan_miss;  // entry was zero, step to the next position
    logic scan_hit;   // return the entry and clear it
    logic scan_end;   // return the end marker and restart
  } sfh_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic rd_nonzero;
    logic scan_at_end;
    logic out_free;
  } sfh_status_t;

endpackage

// ----- rtl/sfh_ctrl.sv -----
module sfh_ctrl
  import sfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tuser,
  output logic        s_tready,
  input  sfh_status_t status,
  output sfh_cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_CNT_UPD  = 3'd2;
  localparam logic [2:0] ST_SCAN_RD  = 3'd3;
  localparam logic [2:0] ST_SCAN_CHK = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == MODE_COUNT) begin
            cmd.cnt_rd = 1'b1;
            state_next = ST_CNT_UPD;
          end else begin
            state_next = ST_SCAN_RD;
          end
        end
      end
      ST_CNT_UPD: begin
        cmd.cnt_upd = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_SCAN_RD: begin
        if (status.scan_at_end) begin
          if (status.out_free) begin
            cmd.scan_end = 1'b1;
            state_next   = ST_IDLE;
          end
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        // The read data register holds while no new read is issued, so a
        // hit can wait here for the output register to drain.
        if (status.rd_nonzero) begin
          if (status.out_free) begin
            cmd.scan_hit = 1'b1;
            state_next   = ST_IDLE;
          end
        end else begin
          cmd.scan_miss = 1'b1;
          state_next    = ST_SCAN_RD;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/sfh_datapath.sv -----
module sfh_datapath
  import sfh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IN_WIDTH-1:0]  s_tdata,
  input  sfh_cmd_t             cmd,
  output sfh_status_t          status,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_WIDTH-1:0] m_tdata,
  output logic                 m_tuser
);

  logic [COUNT_BITS-1:0]  count_mem [2**SYMBOL_BITS];
  logic [COUNT_BITS-1:0]  rd_data;
  logic [SYMBOL_BITS-1:0] rd_addr;
  logic                   rd_en;
  logic [SYMBOL_BITS-1:0] wr_addr;
  logic [COUNT_BITS-1:0]  wr_data;
  logic                   wr_en;

  logic [SYMBOL_BITS-1:0] clr_addr;
  logic [SYMBOL_BITS-1:0] sym;
  logic [DIST_BITS-1:0]   scan_pos;
  logic [DIST_BITS-1:0]   distinct;

  logic [SYMBOL_BITS-1:0] out_symbol;
  logic [COUNT_BITS-1:0]  out_count;
  logic [DIST_BITS-1:0]   out_dist;
  logic                   out_valid;

  assign rd_en   = cmd.cnt_rd | cmd.scan_rd;
  assign rd_addr = cmd.cnt_rd ? s_tdata[SYMBOL_BITS-1:0] : scan_pos[SYMBOL_BITS-1:0];

  always_comb begin
    wr_en   = cmd.clear_wr | cmd.cnt_upd | cmd.scan_hit;
    wr_addr = clr_addr;
    wr_data = '0;
    if (cmd.cnt_upd) begin
      wr_addr = sym;
      wr_data = (rd_data == CNT_MAX) ? CNT_MAX : rd_data + 1'b1;
    end else if (cmd.scan_hit) begin
      wr_addr = scan_pos[SYMBOL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      count_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= count_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd) begin
      sym <= s_tdata[SYMBOL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      scan_pos <= '0;
      distinct <= '0;
    end else begin
      if (cmd.clear_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.scan_end) begin
        scan_pos <= '0;
        distinct <= '0;
      end else begin
        if (cmd.scan_miss || cmd.scan_hit) begin
          scan_pos <= scan_pos + 1'b1;
        end
        if (cmd.cnt_upd && rd_data == '0 && distinct < NUM_SYMS) begin
          distinct <= distinct + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.scan_hit || cmd.scan_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_hit) begin
      out_symbol <= scan_pos[SYMBOL_BITS-1:0];
      out_count  <= rd_data;
      out_valid  <= 1'b1;
      out_dist   <= distinct;
    end else if (cmd.scan_end) begin
      out_symbol <= '0;
      out_count  <= '0;
      out_valid  <= 1'b0;
      out_dist   <= distinct;
    end
  end

  assign m_tdata = OUT_WIDTH'({out_dist, out_count, out_symbol});
  assign m_tuser = out_valid;

  assign status.clear_done  = (clr_addr == {SYMBOL_BITS{1'b1}});
  assign status.rd_nonzero  = (rd_data != '0);
  assign status.scan_at_end = scan_pos[SYMBOL_BITS];
  assign status.out_free    = !m_tvalid || m_tready;

  a_distinct_range: assert property (@(posedge clk) disable iff (rst)
    distinct <= NUM_SYMS)
    else $error("distinct count above the number of symbols");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_hit || cmd.scan_end) |-> (!m_tvalid || m_tready))
    else $error("result loaded over an item not yet taken");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_end |=> (scan_pos == '0 && distinct == '0 && !out_valid))
    else $error("finished scan did not restart");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_hit |=> (m_tvalid && out_valid && out_count != '0))
    else $error("returned entry has a zero count");

endmodule

// ----- rtl/symbol_frequency_histogram.sv -----
// Channel | Dir | tdata (low bit first)                            | tuser
// s_*     | in  | symbol                                           | mode
// m_*     | out | entry_symbol, entry_count, distinct_total, zeros | entry_valid
//
// A count item reads the count memory, then writes back the incremented count.
// A fetch item reads and checks one entry after another until it finds a nonzero entry,
// and returns the end marker when it reaches the end of the store; the single read
// port sets the pace of the scan.
// After reset a clearing pass writes zero to all 2^SYMBOL_BITS entries, one per cycle;
// s_tready stays low until it is done.
// A result waits in the output register; a fetch that finds its result while that
// register is still full stalls until m_tready takes the earlier item.
module symbol_frequency_histogram
  import sfh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_WIDTH-1:0]  s_tdata,   // symbol, zero padding
  input  logic                 s_tuser,   // mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_WIDTH-1:0] m_tdata,   // entry_symbol, entry_count, distinct_total, zeros
  output logic                 m_tuser    // entry_valid
);

  sfh_cmd_t    cmd;
  sfh_status_t status;

  sfh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sfh_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- verif/symbol_frequency_histogram_tb.sv -----
module symbol_frequency_histogram_tb
  import sfh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int NUM_ENTRIES = 1 << SYMBOL_BITS;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] sym;
    logic [COUNT_BITS-1:0]  cnt;
    logic                   hit;
    logic [DIST_BITS-1:0]   total;
  } freq_entry_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_WIDTH-1:0]  s_tdata = '0;   // symbol, zero padding
  logic                 s_tuser = 1'b0; // mode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_WIDTH-1:0] m_tdata;        // entry_symbol, entry_count, distinct_total, zeros
  logic                 m_tuser;        // entry_valid

  // Shadow copy of the histogram state.
  logic [COUNT_BITS-1:0] tally [NUM_ENTRIES];
  logic [DIST_BITS-1:0]  distinct_syms = '0;
  logic [DIST_BITS-1:0]  scan_pos = '0;

  freq_entry_t pending_entries[$];
  logic        last_scan_over = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  symbol_frequency_histogram dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Applies one accepted item to the shadow state and queues the entry it returns.
  // Returns 1 when a fetch finds the scan finished.
  function automatic logic tally_item(input logic mode, input logic [SYMBOL_BITS-1:0] sym);
    freq_entry_t e;
    logic [SYMBOL_BITS-1:0] pos;
    if (mode == MODE_COUNT) begin
      if (tally[sym] == '0 && distinct_syms < NUM_SYMS)
        distinct_syms = distinct_syms + 1'b1;
      if (tally[sym] != CNT_MAX)
        tally[sym] = tally[sym] + 1'b1;
      return 1'b0;
    end
    while (scan_pos < NUM_SYMS) begin
      pos = scan_pos[SYMBOL_BITS-1:0];
      scan_pos = scan_pos + 1'b1;
      if (tally[pos] != '0) begin
        e.sym = pos;
        e.cnt = tally[pos];
        e.hit = 1'b1;
        e.total = distinct_syms;
        tally[pos] = '0;
        pending_entries.push_back(e);
        return 1'b0;
      end
    end
    e = '0;
    e.total = distinct_syms;
    pending_entries.push_back(e);
    scan_pos = '0;
    distinct_syms = '0;
    return 1'b1;
  endfunction

  task automatic send_item(input logic mode, input logic [SYMBOL_BITS-1:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= IN_WIDTH'(sym);
    do @(posedge clk); while (!s_tready);
    last_scan_over = tally_item(mode, sym);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SYMBOL_BITS-1:0] random_symbol(input logic [SYMBOL_BITS-1:0] pool[$]);
    int r = $urandom_range(99);
    if (r < 60) return pool[$urandom_range(pool.size() - 1)];
    if (r < 70) return r[0] ? '1 : '0;
    return SYMBOL_BITS'($urandom);
  endfunction

  task automatic report_mismatch(input freq_entry_t want, input freq_entry_t got);
    error_count++;
    if (error_count <= 10)
      $display("entry mismatch at cycle %0d: expected sym %h count %0d valid %b total %0d, %s",
               cycle_count, want.sym, want.cnt, want.hit, want.total,
               $sformatf("got sym %h count %0d valid %b total %0d",
                         got.sym, got.cnt, got.hit, got.total));
  endtask

  always @(posedge clk) begin
    freq_entry_t got;
    freq_entry_t want;
    m_tready <= ($urandom_range(99) >= stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got.sym   = m_tdata[SYMBOL_BITS-1:0];
      got.cnt   = m_tdata[SYMBOL_BITS +: COUNT_BITS];
      got.total = m_tdata[SYMBOL_BITS+COUNT_BITS +: DIST_BITS];
      got.hit   = m_tuser;
      if (pending_entries.size() == 0) begin
        // Nothing was due: report it against an all-X expectation.
        want = 'x;
        report_mismatch(want, got);
      end else begin
        want = pending_entries.pop_front();
        if (got.sym !== want.sym || got.cnt !== want.cnt || got.hit !== want.hit ||
            got.total !== want.total)
          report_mismatch(want, got);
      end
    end
  end

  task automatic test_empty_scan();
    send_item(MODE_FETCH, 16'h1234);
    wait_drained();
  endtask

  task automatic test_directed_block();
    logic [SYMBOL_BITS-1:0] firsts[$] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h00FF,
                                         16'hFF00, 16'h5555, 16'hAAAA, 16'hFFFF, 16'hFFFF,
                                         16'h0000};
    foreach (firsts[i]) send_item(MODE_COUNT, firsts[i]);
    // The symbol field of a fetch is ignored.
    send_item(MODE_FETCH, 16'hFFFF);
    send_item(MODE_FETCH, 16'h0000);
    // Symbol 0 is behind the scan now, so it waits for the next scan.
    send_item(MODE_COUNT, 16'h0000);
    send_item(MODE_COUNT, 16'h7FFF);
    do send_item(MODE_FETCH, SYMBOL_BITS'($urandom)); while (!last_scan_over);
    wait_drained();
  endtask

  // One block of symbols followed by a full scan, with counts mixed into the scan and a
  // few early fetches among the counts.
  task automatic test_random_block(input int idle_pct, input int stall);
    logic [SYMBOL_BITS-1:0] pool[$];
    int n_counts;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    repeat ($urandom_range(24, 4)) pool.push_back(SYMBOL_BITS'($urandom));
    n_counts = $urandom_range(170, 130);
    for (int i = 0; i < n_counts; i++) begin
      if (i > 20 && $urandom_range(99) < 4)
        send_item(MODE_FETCH, SYMBOL_BITS'($urandom));
      else
        send_item(MODE_COUNT, random_symbol(pool));
    end
    do begin
      if ($urandom_range(99) < 25)
        send_item(MODE_COUNT, random_symbol(pool));
      else
        send_item(MODE_FETCH, SYMBOL_BITS'($urandom));
    end while (!last_scan_over);
    wait_drained();
  endtask

  initial begin
    foreach (tally[i]) tally[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_scan();
    test_directed_block();
    test_random_block(0, 0);
    test_random_block(55, 0);
    test_random_block(0, 55);
    test_random_block(38, 38);
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_entries.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
